// File: rtl/ip_prefix_mask_unit_core_defines.svh
// Assertion macros used by the checker file of the prefix/mask unit.
`ifndef IP_PREFIX_MASK_UNIT_CORE_DEFINES_SVH
`define IP_PREFIX_MASK_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is held.
`define IPM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is held.
`define IPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after reset is sampled low.
`define IPM_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge aclk) (!aresetn) |=> (cons)) else $error(msg);

`endif

// File: rtl/ipm_pkg.sv
`default_nettype none

package ipm_pkg;

    localparam int ADDR_W  = 128;
    localparam int HALF_W  = 64;
    localparam int PLEN_W  = 8;
    localparam int NBYTES  = 16;
    localparam int BCNT_W  = 4;
    localparam int V4_BITS = 32;

    // Address widths as prefix-length values
    localparam logic [PLEN_W-1:0] V4_WIDTH = 8'd32;
    localparam logic [PLEN_W-1:0] V6_WIDTH = 8'd128;

    // IPv6 all-nodes multicast (ff02::1)
    localparam logic [ADDR_W-1:0] ALL_NODES = {64'hFF02_0000_0000_0000, 64'h0000_0000_0000_0001};

    typedef enum logic [2:0] {
        OP_MASK    = 3'd0,
        OP_PREFIX  = 3'd1,
        OP_NETWORK = 3'd2,
        OP_HOST    = 3'd3,
        OP_BCAST   = 3'd4,
        OP_COMBINE = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NONCONTIG = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_OVERLAP   = 2'd3
    } status_t;

    typedef logic [BCNT_W-1:0] bcnt_t;

    // Raw input beat fields
    typedef struct packed {
        logic [2:0]        opcode;
        logic              is_v6;
        logic [HALF_W-1:0] addr_hi;
        logic [HALF_W-1:0] addr_lo;
        logic [PLEN_W-1:0] prefix_len;
        logic [HALF_W-1:0] other_hi;
        logic [HALF_W-1:0] other_lo;
    } in_t;

    // Decode stage: operands aligned so the first address bit is bit 127
    typedef struct packed {
        op_t                      op;
        logic                     v6;
        logic                     too_long;
        logic [PLEN_W-1:0]        plen;
        logic [ADDR_W-1:0]        addr;
        logic [ADDR_W-1:0]        other;
        logic [ADDR_W-1:0]        mask;
        bcnt_t [NBYTES-1:0]       cnt;
        logic                     noncontig;
    } s1_t;

    // Compute stage: result still top aligned
    typedef struct packed {
        logic              v6;
        logic [ADDR_W-1:0] res;
        logic [PLEN_W-1:0] pout;
        status_t           status;
    } s2_t;

endpackage

`default_nettype wire

// File: rtl/ip_prefix_mask_unit_core.sv
// Channel | Direction | tdata (low bit up)                              | tuser
// s_      | in        | addr_hi, addr_lo, prefix_len, other_hi, other_lo | opcode, is_v6
// m_      | out       | result_hi, result_lo, prefix_out                 | status
//
// Three register stages: decode (align, mask, per-byte ones count),
// compute (leading-one count and result select), output register.
// One beat per cycle while the output is not stalled.
// Reset (aresetn low, synchronous) clears the stage valid bits only.
// A stall on m_tready holds every stage that has no empty slot behind it;
// stages with bubbles keep filling, so s_tready drops only when all are full.
`default_nettype none

module ip_prefix_mask_unit_core
    import ipm_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [263:0] s_tdata,  // addr_hi, addr_lo, prefix_len, other_hi, other_lo
    input  wire logic [3:0]   s_tuser,  // opcode, is_v6
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [135:0]      m_tdata,  // result_hi, result_lo, prefix_out
    output logic [1:0]        m_tuser   // status
);

    in_t   in_item;
    logic  st1_valid;
    s1_t   st1_data;
    logic  st2_valid;
    s2_t   st2_data;
    logic  load1;
    logic  load2;
    logic  load3;

    logic              m_valid_reg;
    logic              m_valid_next;
    logic [135:0]      m_data_reg;
    logic [135:0]      m_data_next;
    logic [1:0]        m_user_reg;

    // Unpack the input beat
    assign in_item.opcode     = s_tuser[2:0];
    assign in_item.is_v6      = s_tuser[3];
    assign in_item.addr_hi    = s_tdata[63:0];
    assign in_item.addr_lo    = s_tdata[127:64];
    assign in_item.prefix_len = s_tdata[135:128];
    assign in_item.other_hi   = s_tdata[199:136];
    assign in_item.other_lo   = s_tdata[263:200];

    // Advance a stage when it is empty or the next one advances
    assign load3    = !m_valid_reg || m_tready;
    assign load2    = !st2_valid || load3;
    assign load1    = !st1_valid || load2;
    assign s_tready = load1;

    ipm_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .load      (load1),
        .in_item   (in_item),
        .st1_valid (st1_valid),
        .st1_data  (st1_data)
    );

    ipm_compute u_compute (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .st1_valid (st1_valid),
        .st1_data  (st1_data),
        .load      (load2),
        .st2_valid (st2_valid),
        .st2_data  (st2_data)
    );

    // Move the result back to the field layout of its family
    always_comb begin
        logic [HALF_W-1:0] res_hi;
        logic [HALF_W-1:0] res_lo;
        if (st2_data.v6) begin
            res_hi = st2_data.res[ADDR_W-1:HALF_W];
            res_lo = st2_data.res[HALF_W-1:0];
        end else begin
            res_hi = '0;
            res_lo = {{(HALF_W-V4_BITS){1'b0}}, st2_data.res[ADDR_W-1 -: V4_BITS]};
        end
        m_data_next = {st2_data.pout, res_lo, res_hi};
    end

    assign m_valid_next = load3 ? st2_valid : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Load the output beat
    always_ff @(posedge aclk) begin
        if (load3 && st2_valid) begin
            m_data_reg <= m_data_next;
            m_user_reg <= st2_data.status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

// File: rtl/ipm_decode.sv
`default_nettype none

module ipm_decode
    import ipm_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    input  wire logic load,
    input  wire in_t  in_item,
    output logic      st1_valid,
    output s1_t       st1_data
);

    logic st1_valid_reg;
    logic st1_valid_next;
    s1_t  st1_data_reg;
    s1_t  st1_data_next;

    // Count leading ones of one byte
    function automatic bcnt_t lead_ones8(input logic [7:0] b);
        bcnt_t n;
        logic  run;
        n   = '0;
        run = 1'b1;
        for (int i = 7; i >= 0; i--) begin
            run = run & b[i];
            n   = n + {{(BCNT_W-1){1'b0}}, run};
        end
        return n;
    endfunction

    // Align operands, decode the prefix mask, count ones per byte
    always_comb begin
        logic [ADDR_W-1:0] a_l;
        logic [ADDR_W-1:0] o_l;
        logic [ADDR_W-1:0] m_l;
        logic [4:0]        pbytes;
        logic [7:0]        part;

        if (in_item.is_v6) begin
            a_l = {in_item.addr_hi, in_item.addr_lo};
            o_l = {in_item.other_hi, in_item.other_lo};
        end else begin
            a_l = {in_item.addr_lo[V4_BITS-1:0], {(ADDR_W-V4_BITS){1'b0}}};
            o_l = {in_item.other_lo[V4_BITS-1:0], {(ADDR_W-V4_BITS){1'b0}}};
        end

        pbytes = in_item.prefix_len[PLEN_W-1:3];
        part   = ~(8'hFF >> in_item.prefix_len[2:0]);
        for (int b = 0; b < NBYTES; b++) begin
            if (pbytes > 5'(b)) begin
                m_l[ADDR_W-1-8*b -: 8] = 8'hFF;
            end else if (pbytes == 5'(b)) begin
                m_l[ADDR_W-1-8*b -: 8] = part;
            end else begin
                m_l[ADDR_W-1-8*b -: 8] = 8'h00;
            end
            st1_data_next.cnt[b] = lead_ones8(a_l[ADDR_W-1-8*b -: 8]);
        end

        st1_data_next.op        = op_t'(in_item.opcode);
        st1_data_next.v6        = in_item.is_v6;
        st1_data_next.too_long  = in_item.is_v6 ? (in_item.prefix_len > V6_WIDTH)
                                                : (in_item.prefix_len > V4_WIDTH);
        st1_data_next.plen      = in_item.prefix_len;
        st1_data_next.addr      = a_l;
        st1_data_next.other     = o_l;
        st1_data_next.mask      = m_l;
        // A one right below a zero breaks the run of ones
        st1_data_next.noncontig = |((a_l << 1) & ~a_l);
    end

    assign st1_valid_next = load ? in_valid : st1_valid_reg;

    // Clear valid under reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
        end
    end

    // Capture the beat when the stage advances
    always_ff @(posedge aclk) begin
        if (load && in_valid) begin
            st1_data_reg <= st1_data_next;
        end
    end

    assign st1_valid = st1_valid_reg;
    assign st1_data  = st1_data_reg;

endmodule

`default_nettype wire

// File: rtl/ipm_compute.sv
`default_nettype none

module ipm_compute
    import ipm_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic st1_valid,
    input  wire s1_t  st1_data,
    input  wire logic load,
    output logic      st2_valid,
    output s2_t       st2_data
);

    logic st2_valid_reg;
    logic st2_valid_next;
    s2_t  st2_data_reg;
    s2_t  st2_data_next;

    // Leading-one count: first byte that is not all ones ends the run
    logic [PLEN_W-1:0] count;

    always_comb begin
        count = V6_WIDTH;
        for (int b = NBYTES - 1; b >= 0; b--) begin
            if (st1_data.cnt[b] != bcnt_t'(8)) begin
                count = {1'b0, 4'(b), 3'b000} + {4'b0000, st1_data.cnt[b]};
            end
        end
    end

    // Select the result per opcode
    always_comb begin
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] m;
        logic [ADDR_W-1:0] o;

        a = st1_data.addr;
        m = st1_data.mask;
        o = st1_data.other;

        st2_data_next.v6     = st1_data.v6;
        st2_data_next.res    = '0;
        st2_data_next.pout   = st1_data.plen;
        st2_data_next.status = ST_OK;

        case (st1_data.op)
            OP_PREFIX: begin
                st2_data_next.res    = a;
                st2_data_next.pout   = count;
                st2_data_next.status = st1_data.noncontig ? ST_NONCONTIG : ST_OK;
            end
            OP_MASK, OP_NETWORK, OP_HOST, OP_BCAST, OP_COMBINE: begin
                if (st1_data.too_long) begin
                    st2_data_next.status = ST_TOO_LONG;
                end else begin
                    case (st1_data.op)
                        OP_MASK:    st2_data_next.res = m;
                        OP_NETWORK: st2_data_next.res = a & m;
                        OP_HOST:    st2_data_next.res = a & ~m;
                        OP_BCAST:   st2_data_next.res = st1_data.v6 ? ALL_NODES : (a | ~m);
                        OP_COMBINE: begin
                            if (|(o & m)) begin
                                st2_data_next.status = ST_OVERLAP;
                            end else begin
                                st2_data_next.res = (a & m) | o;
                            end
                        end
                        default: st2_data_next.res = '0;
                    endcase
                end
            end
            default: begin
                // Unused opcodes drop everything to zero
                st2_data_next.pout = '0;
            end
        endcase
    end

    assign st2_valid_next = load ? st1_valid : st2_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
        end else begin
            st2_valid_reg <= st2_valid_next;
        end
    end

    // Advance the payload with its valid
    always_ff @(posedge aclk) begin
        if (load && st1_valid) begin
            st2_data_reg <= st2_data_next;
        end
    end

    assign st2_valid = st2_valid_reg;
    assign st2_data  = st2_data_reg;

endmodule

`default_nettype wire

// File: rtl/ipm_checker.sv
`default_nettype none
`include "ip_prefix_mask_unit_core_defines.svh"

module ipm_checker
    import ipm_pkg::*;
(
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [263:0] s_tdata,
    input wire logic [3:0]   s_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [135:0] m_tdata,
    input wire logic [1:0]   m_tuser
);

    // Output channel empties on reset
    `IPM_ASSERT_RST(a_rst_empty, !m_tvalid, "m_tvalid high after reset")

    // Too-long and overlap results carry a zero address
    `IPM_ASSERT_NOW(a_long_zero, m_tvalid && (m_tuser == ST_TOO_LONG), m_tdata[127:0] == 128'd0, "too-long prefix with nonzero result")
    `IPM_ASSERT_NOW(a_ovl_zero, m_tvalid && (m_tuser == ST_OVERLAP), m_tdata[127:0] == 128'd0, "overlap with nonzero result")

    // A broken mask can never count a full run of ones
    `IPM_ASSERT_NOW(a_nc_count, m_tvalid && (m_tuser == ST_NONCONTIG), m_tdata[135:128] < 8'd127, "non-contiguous mask with full count")

    // Stalled beat holds
    `IPM_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output beat changed under stall")

endmodule

bind ip_prefix_mask_unit_core ipm_checker u_ipm_checker (.*);

`default_nettype wire

// File: tb/sv/tb_top.sv
module tb_top;
    import ipm_pkg::*;

    // Opcodes outside the decoded set; the block must answer them with zeros
    localparam logic [2:0] OPC_SPARE6 = 3'd6;
    localparam logic [2:0] OPC_SPARE7 = 3'd7;

    localparam logic [127:0] V4_SPAN = {96'd0, 32'hFFFF_FFFF};
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 64;

    typedef struct packed {
        logic [63:0] res_hi;
        logic [63:0] res_lo;
        logic [7:0]  pout;
        status_t     status;
    } cidr_result_t;

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [263:0] s_tdata  = '0;  // addr_hi, addr_lo, prefix_len, other_hi, other_lo
    logic [3:0]   s_tuser  = '0;  // opcode, is_v6
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;        // result_hi, result_lo, prefix_out
    logic [1:0]   m_tuser;        // status

    cidr_result_t pending_results[$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    bit           free_run       = 1'b0;
    bit           hold_off_req   = 1'b0;

    ip_prefix_mask_unit_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached", $time);
            $display("simulation failed");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Netmask with the top p bits of the address set
    function automatic logic [127:0] prefix_bits(logic v6, int unsigned p);
        if (p == 0) return '0;
        if (v6) return {128{1'b1}} << (128 - p);
        return (V4_SPAN << (32 - p)) & V4_SPAN;
    endfunction

    // Expected result of one input beat
    function automatic cidr_result_t cidr_predict(logic [2:0] opc, logic v6,
                                                  logic [63:0] a_hi, logic [63:0] a_lo,
                                                  logic [7:0] plen,
                                                  logic [63:0] o_hi, logic [63:0] o_lo);
        cidr_result_t r;
        logic [127:0] span, addr, other, mask, res;
        int unsigned  width, ones;
        span     = v6 ? {128{1'b1}} : V4_SPAN;
        width    = v6 ? 128 : 32;
        addr     = {a_hi, a_lo} & span;
        other    = {o_hi, o_lo} & span;
        res      = '0;
        r.pout   = plen;
        r.status = ST_OK;
        if (opc > OP_COMBINE) begin
            r.pout = '0;
        end else if (opc == OP_PREFIX) begin
            // count leading ones, then flag any one below the first zero
            ones = 0;
            while (ones < width && addr[width - 1 - ones]) ones++;
            mask   = prefix_bits(v6, ones);
            res    = addr;
            r.pout = 8'(ones);
            if (addr != mask) r.status = ST_NONCONTIG;
        end else if (plen > width) begin
            r.status = ST_TOO_LONG;
        end else begin
            mask = prefix_bits(v6, plen);
            case (opc)
                OP_MASK:    res = mask;
                OP_NETWORK: res = addr & mask;
                OP_HOST:    res = addr & ~mask & span;
                OP_BCAST:   res = v6 ? ALL_NODES : ((addr | ~mask) & span);
                default: begin
                    if ((other & mask) != '0) r.status = ST_OVERLAP;
                    else res = (addr & mask) | other;
                end
            endcase
        end
        r.res_hi = res[127:64];
        r.res_lo = res[63:0];
        return r;
    endfunction

    // Offer one beat after a random gap (none in free-run mode), record its expected result on acceptance
    task automatic send_beat(logic [2:0] opc, logic v6, logic [63:0] a_hi, logic [63:0] a_lo,
                             logic [7:0] plen, logic [63:0] o_hi, logic [63:0] o_lo);
        int gap;
        gap = free_run ? 0 : idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {o_lo, o_hi, plen, a_lo, a_hi};
        s_tuser  <= {v6, opc};
        do @(posedge aclk); while (s_tready !== 1'b1);
        pending_results.push_back(cidr_predict(opc, v6, a_hi, a_lo, plen, o_hi, o_lo));
    endtask

    // Random beat, mostly well-formed masks and non-overlapping hosts
    task automatic send_random_item();
        logic [2:0]   opc;
        logic         v6;
        logic [63:0]  ah, al, oh, ol;
        logic [7:0]   plen;
        logic [127:0] mask, span, addr;
        int unsigned  width, sel, p, q;
        sel = $urandom_range(0, 99);
        if (sel < 3) opc = sel[0] ? OPC_SPARE7 : OPC_SPARE6;
        else opc = 3'($urandom_range(0, 5));
        v6    = 1'($urandom_range(0, 1));
        width = v6 ? 128 : 32;
        span  = v6 ? {128{1'b1}} : V4_SPAN;
        sel   = $urandom_range(0, 99);
        if (sel < 8) p = $urandom_range(width + 1, 255);
        else if (sel < 14) p = 0;
        else if (sel < 20) p = width;
        else p = $urandom_range(0, width);
        plen = 8'(p);
        q    = (p > width) ? $urandom_range(0, width) : p;
        mask = prefix_bits(v6, q);
        ah   = rand64();
        al   = rand64();
        oh   = rand64();
        ol   = rand64();
        if (opc == OP_PREFIX) begin
            // contiguous mask, a mask with one bit flipped, or noise
            sel = $urandom_range(0, 9);
            if (sel < 6) addr = mask;
            else if (sel < 9) addr = mask ^ (128'd1 << $urandom_range(0, width - 1));
            else addr = {ah, al};
            {ah, al} = (addr & span) | ({ah, al} & ~span);
        end
        if (opc == OP_COMBINE && $urandom_range(0, 3) != 0) {oh, ol} = {oh, ol} & ~mask;
        send_beat(opc, v6, ah, al, plen, oh, ol);
    endtask

    function automatic void report_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // Check each accepted result beat and drive m_tready with random stalls
    initial begin : result_sink
        cidr_result_t want;
        int           stall_left;
        int           g;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with nothing pending, expected none, got %h/%h",
                             $time, m_tdata, m_tuser);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    report_field("result_hi", want.res_hi, m_tdata[63:0]);
                    report_field("result_lo", want.res_lo, m_tdata[127:64]);
                    report_field("prefix_out", 64'(want.pout), 64'(m_tdata[135:128]));
                    report_field("status", 64'(want.status), 64'(m_tuser));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                g = free_run ? 0 : idle_gap();
                if (g > 0) begin
                    stall_left = g - 1;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    task automatic test_mask_build();
        send_beat(OP_MASK, 1'b0, '1, '1, 8'd0, '1, '1);
        send_beat(OP_MASK, 1'b0, '0, '0, 8'd32, '0, '0);
        send_beat(OP_MASK, 1'b1, '0, '0, 8'd64, '0, '0);
        send_beat(OP_MASK, 1'b1, '0, '0, 8'd128, '0, '0);
        // prefix one past the address width, and the largest prefix field
        send_beat(OP_MASK, 1'b0, '0, '0, 8'd33, '0, '0);
        send_beat(OP_MASK, 1'b1, '1, '1, 8'd255, '1, '1);
    endtask

    task automatic test_prefix_count();
        // IPv4 /24 with junk above bit 31, prefix field ignored
        send_beat(OP_PREFIX, 1'b0, '1, 64'hDEAD_BEEF_FFFF_FF00, 8'd200, '0, '0);
        send_beat(OP_PREFIX, 1'b0, '0, 64'h0000_0000_FFFF_FFFF, 8'd0, '0, '0);
        send_beat(OP_PREFIX, 1'b0, '0, '0, 8'd255, '0, '0);
        send_beat(OP_PREFIX, 1'b0, '0, 64'h0000_0000_FF00_FF00, 8'd16, '0, '0);
        send_beat(OP_PREFIX, 1'b1, '1, '1, 8'd0, '0, '0);
        send_beat(OP_PREFIX, 1'b1, '1, 64'h8000_0000_0000_0000, 8'd64, '0, '0);
        send_beat(OP_PREFIX, 1'b1, 64'hFFFF_0000_0000_0000, 64'd1, 8'd16, '0, '0);
    endtask

    task automatic test_address_split();
        send_beat(OP_NETWORK, 1'b0, '1, '1, 8'd24, '1, '1);
        send_beat(OP_NETWORK, 1'b1, '1, '1, 8'd0, '0, '0);
        send_beat(OP_HOST, 1'b0, '1, '1, 8'd8, '0, '0);
        send_beat(OP_HOST, 1'b1, rand64(), rand64(), 8'd127, '0, '0);
        send_beat(OP_BCAST, 1'b0, '0, 64'h0000_0000_C0A8_0101, 8'd24, '0, '0);
        send_beat(OP_BCAST, 1'b0, '1, '1, 8'd32, '0, '0);
        // IPv6 broadcast always gives all-nodes unless the prefix is too long
        send_beat(OP_BCAST, 1'b1, rand64(), rand64(), 8'd48, '0, '0);
        send_beat(OP_BCAST, 1'b1, rand64(), rand64(), 8'd129, '0, '0);
    endtask

    task automatic test_combine();
        send_beat(OP_COMBINE, 1'b0, '0, 64'h0000_0000_C0A8_0100, 8'd24,
                  '1, 64'hFFFF_FFFF_0000_0042);
        send_beat(OP_COMBINE, 1'b0, '0, 64'h0000_0000_C0A8_0100, 8'd24,
                  '0, 64'h0000_0000_0000_0100);
        send_beat(OP_COMBINE, 1'b1, rand64(), rand64(), 8'd64, '0, rand64());
        send_beat(OP_COMBINE, 1'b1, rand64(), rand64(), 8'd64, 64'd1, rand64());
    endtask

    task automatic test_unused_opcodes();
        send_beat(OPC_SPARE6, 1'b1, rand64(), rand64(), 8'd40, rand64(), rand64());
        send_beat(OPC_SPARE7, 1'b0, rand64(), rand64(), 8'd255, rand64(), rand64());
    endtask

    task automatic test_random_traffic(int count);
        repeat (count) send_random_item();
    endtask

    // Hold the result side off while beats keep coming, so the pipe fills up
    task automatic test_backpressure(int count);
        free_run     = 1'b1;
        hold_off_req = 1'b1;
        repeat (count) send_random_item();
        free_run = 1'b0;
    endtask

    initial begin : stimulus
        int waited;
        aresetn <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_mask_build();
        test_prefix_count();
        test_address_split();
        test_combine();
        test_unused_opcodes();
        test_random_traffic(600);
        test_backpressure(80);
        test_random_traffic(620);
        s_tvalid <= 1'b0;

        // drain outstanding results, then let the pipe settle
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived, expected none left, got %0d",
                     $time, pending_results.size(), pending_results.size());
            mismatch_count++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ipm_pkg.sv
rtl/ipm_decode.sv
rtl/ipm_compute.sv
rtl/ip_prefix_mask_unit_core.sv
rtl/ipm_checker.sv
tb/sv/tb_top.sv
